// ----- design/mrrm_pkg.sv -----
// Shared types, codes and the CRC-16/Modbus byte update for the read-registers master.
package mrrm_pkg;

  localparam int MaxRegisters = 125;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  COUNT_HIGH_BYTE = 8'h00;

  localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd1;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd120;

  // Input item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result item kinds
  localparam logic [1:0] RK_REQUEST = 2'd0;
  localparam logic [1:0] RK_DATA    = 2'd1;
  localparam logic [1:0] RK_DONE    = 2'd2;

  // Done status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TIMEOUT    = 3'd1;
  localparam logic [2:0] ST_CRC        = 3'd2;
  localparam logic [2:0] ST_ADDR_FUNC  = 3'd3;
  localparam logic [2:0] ST_BYTE_COUNT = 3'd4;
  localparam logic [2:0] ST_BAD_COUNT  = 3'd5;

  // Configuration register indexes
  localparam logic REG_SLAVE_ADDRESS = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       last;
    logic [2:0] status;
  } result_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/modbus_rtu_register_read_master_core.sv -----
// Top level of the Modbus RTU read-holding-registers master.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  s_*      | s_tvalid / s_tready      | tuser kind; tdata address, count, rx byte
//  m_*      | m_tvalid / m_tready      | tuser result kind; tdata byte, status; tlast
//  apb      | psel, penable, pready=1  | 0x0 slave_address, 0x4 timeout_ticks
//
// A received byte, tick or bad-count start is handled by the reply logic alone; a good start
// hands the eight request bytes to the request sequencer, which emits a byte a cycle unless m_tready stalls it.
// Reset (rst, synchronous) drops any transaction, empties the input and output
// registers and restores slave_address 1 and timeout_ticks 120.
// The input register, if empty, takes a new item while a result waits in the output register;
// a stall on m_tready holds the sequencer and the input register in place.
module modbus_rtu_register_read_master_core #(
  parameter int MAX_REGISTERS = mrrm_pkg::MaxRegisters
) (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] register_address, [22:16] register_count,
                                 // [30:23] received_byte, [31] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] byte_value, [10:8] status, [15:11] zero
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast,   // last_of_run
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [7:0]  slave_address;
  logic [15:0] timeout_ticks;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= mrrm_pkg::SLAVE_ADDRESS_RESET;
      timeout_ticks <= mrrm_pkg::TIMEOUT_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        mrrm_pkg::REG_SLAVE_ADDRESS: slave_address <= pwdata[7:0];
        mrrm_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mrrm_pkg::REG_SLAVE_ADDRESS: prdata = {24'd0, slave_address};
      mrrm_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks};
      default:                     prdata = 32'd0;
    endcase
  end

  // Input register
  logic        in_valid;
  logic [1:0]  in_kind;
  logic [15:0] in_addr;
  logic [6:0]  in_cnt;
  logic [7:0]  in_byte;

  // Engine control
  logic              out_free;
  logic              take;
  logic              rep_step;
  logic              start_ok;
  logic              gen_busy;
  mrrm_pkg::result_t gen_res;
  mrrm_pkg::result_t rep_res;
  mrrm_pkg::result_t eng_res;

  // Output register can load when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  // Hold input items while the sequencer is emitting a request
  assign take     = !gen_busy && out_free;
  assign rep_step = in_valid && take;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_addr <= s_tdata[15:0];
      in_cnt  <= s_tdata[22:16];
      in_byte <= s_tdata[30:23];
    end
  end

  mrrm_reply #(
    .MAX_REGISTERS(MAX_REGISTERS)
  ) u_reply (
    .clk            (clk),
    .rst            (rst),
    .step           (rep_step),
    .kind           (in_kind),
    .register_count (in_cnt),
    .received_byte  (in_byte),
    .slave_address  (slave_address),
    .timeout_ticks  (timeout_ticks),
    .start_ok       (start_ok),
    .res            (rep_res)
  );

  mrrm_req_gen u_req_gen (
    .clk              (clk),
    .rst              (rst),
    .load             (start_ok),
    .advance          (out_free),
    .slave_address    (slave_address),
    .register_address (in_addr),
    .register_count   (in_cnt),
    .busy             (gen_busy),
    .res              (gen_res)
  );

  // Request bytes come from the sequencer, everything else from the reply logic
  assign eng_res = gen_res.valid ? gen_res : rep_res;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= eng_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && eng_res.valid) begin
      m_tdata <= {5'd0, eng_res.status, eng_res.byte_value};
      m_tuser <= eng_res.kind;
      m_tlast <= eng_res.last;
    end
  end

  // No reply-side item is processed while a request is being emitted
  a_busy_blocks_step: assert property (@(posedge clk) disable iff (rst)
    gen_busy |-> !rep_step)
    else $error("item processed during request emission");

  // Only one source drives a result in any cycle
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(gen_res.valid && rep_res.valid))
    else $error("request and reply results collide");

  // A result is only produced when the output register can take it
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    eng_res.valid |-> out_free)
    else $error("result produced while output register is full");

  // A good start leaves the sequencer busy for the remaining request bytes
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start_ok |=> gen_busy)
    else $error("sequencer idle after good start");

  // Done results always close a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (eng_res.valid && eng_res.kind == mrrm_pkg::RK_DONE) |-> eng_res.last)
    else $error("done result without last");

endmodule

// ----- design/mrrm_req_gen.sv -----
// Request sequencer: emits the eight request bytes with a byte-wise CRC.
module mrrm_req_gen (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 advance,
  input  logic [7:0]           slave_address,
  input  logic [15:0]          register_address,
  input  logic [6:0]           register_count,
  output logic                 busy,
  output mrrm_pkg::result_t    res
);

  logic [2:0]  idx;
  logic [15:0] crc;
  logic [7:0]  slave;
  logic [15:0] addr;
  logic [6:0]  cnt;
  logic [7:0]  byte_cur;
  logic [15:0] crc_cur;
  logic        emit;

  assign emit    = busy ? advance : load;
  assign crc_cur = busy ? crc : mrrm_pkg::CRC_INIT;

  always_comb begin
    case (idx)
      3'd0:    byte_cur = busy ? slave : slave_address;
      3'd1:    byte_cur = mrrm_pkg::FUNC_READ_HOLDING;
      3'd2:    byte_cur = addr[15:8];
      3'd3:    byte_cur = addr[7:0];
      3'd4:    byte_cur = mrrm_pkg::COUNT_HIGH_BYTE;
      3'd5:    byte_cur = {1'b0, cnt};
      3'd6:    byte_cur = crc[7:0];
      default: byte_cur = crc[15:8];
    endcase
  end

  always_comb begin
    res            = '0;
    res.valid      = emit;
    res.kind       = mrrm_pkg::RK_REQUEST;
    res.byte_value = byte_cur;
    res.last       = (idx == 3'd7);
    res.status     = mrrm_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (emit) begin
      idx  <= idx + 3'd1;
      busy <= (idx != 3'd7);
    end
  end

  // Hold the CRC once the six header bytes are in; the last two bytes send it
  always_ff @(posedge clk) begin
    if (emit && (idx < 3'd6)) begin
      crc <= mrrm_pkg::crc_add(crc_cur, byte_cur);
    end
    if (load && !busy) begin
      slave <= slave_address;
      addr  <= register_address;
      cnt   <= register_count;
    end
  end

endmodule

// ----- design/mrrm_reply.sv -----
// Transaction state: count check, reply framing, CRC and header checks, timeout.
module mrrm_reply #(
  parameter int MAX_REGISTERS = mrrm_pkg::MaxRegisters
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [1:0]           kind,
  input  logic [6:0]           register_count,
  input  logic [7:0]           received_byte,
  input  logic [7:0]           slave_address,
  input  logic [15:0]          timeout_ticks,
  output logic                 start_ok,
  output mrrm_pkg::result_t    res
);

  logic        waiting_reply, waiting_reply_next;
  logic [8:0]  bytes_received, bytes_received_next;
  logic [7:0]  expected_data_bytes, expected_data_bytes_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_seen, crc_low_seen_next;
  logic        header_mismatch, header_mismatch_next;
  logic        count_mismatch, count_mismatch_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic        clear;
  logic [8:0]  crc_pos;
  logic [15:0] ticks_inc;
  logic [15:0] rx_crc;

  // Index of the CRC low byte in the reply frame
  assign crc_pos   = {1'b0, expected_data_bytes} + 9'd3;
  assign ticks_inc = (elapsed_ticks != 16'hFFFF) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  assign rx_crc    = {received_byte, crc_low_seen};

  always_comb begin
    waiting_reply_next       = waiting_reply;
    bytes_received_next      = bytes_received;
    expected_data_bytes_next = expected_data_bytes;
    running_crc_next         = running_crc;
    crc_low_seen_next        = crc_low_seen;
    header_mismatch_next     = header_mismatch;
    count_mismatch_next      = count_mismatch;
    elapsed_ticks_next       = elapsed_ticks;
    clear                    = 1'b0;
    start_ok                 = 1'b0;
    res                      = '0;
    if (step) begin
      case (kind)
        mrrm_pkg::KIND_START: begin
          clear = 1'b1;
          if (register_count == 7'd0 || register_count > 7'(MAX_REGISTERS)) begin
            res.valid  = 1'b1;
            res.kind   = mrrm_pkg::RK_DONE;
            res.last   = 1'b1;
            res.status = mrrm_pkg::ST_BAD_COUNT;
          end else begin
            start_ok = 1'b1;
          end
        end
        mrrm_pkg::KIND_BYTE: begin
          if (waiting_reply) begin
            bytes_received_next = bytes_received + 9'd1;
            if (bytes_received < crc_pos) begin
              running_crc_next = mrrm_pkg::crc_add(running_crc, received_byte);
              if (bytes_received == 9'd0 && received_byte != slave_address) begin
                header_mismatch_next = 1'b1;
              end
              if (bytes_received == 9'd1 && received_byte != mrrm_pkg::FUNC_READ_HOLDING) begin
                header_mismatch_next = 1'b1;
              end
              if (bytes_received == 9'd2 && received_byte != expected_data_bytes) begin
                count_mismatch_next = 1'b1;
              end
              if (bytes_received >= 9'd3) begin
                res.valid      = 1'b1;
                res.kind       = mrrm_pkg::RK_DATA;
                res.byte_value = received_byte;
              end
            end else if (bytes_received == crc_pos) begin
              crc_low_seen_next = received_byte;
            end else begin
              clear     = 1'b1;
              res.valid = 1'b1;
              res.kind  = mrrm_pkg::RK_DONE;
              res.last  = 1'b1;
              // CRC beats header, header beats byte count
              if (rx_crc != running_crc) begin
                res.status = mrrm_pkg::ST_CRC;
              end else if (header_mismatch) begin
                res.status = mrrm_pkg::ST_ADDR_FUNC;
              end else if (count_mismatch) begin
                res.status = mrrm_pkg::ST_BYTE_COUNT;
              end else begin
                res.status = mrrm_pkg::ST_OK;
              end
            end
          end
        end
        mrrm_pkg::KIND_TICK: begin
          if (waiting_reply) begin
            elapsed_ticks_next = ticks_inc;
            if (ticks_inc >= timeout_ticks) begin
              clear      = 1'b1;
              res.valid  = 1'b1;
              res.kind   = mrrm_pkg::RK_DONE;
              res.last   = 1'b1;
              res.status = mrrm_pkg::ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
    if (clear) begin
      waiting_reply_next       = 1'b0;
      bytes_received_next      = 9'd0;
      expected_data_bytes_next = 8'd0;
      running_crc_next         = mrrm_pkg::CRC_INIT;
      crc_low_seen_next        = 8'd0;
      header_mismatch_next     = 1'b0;
      count_mismatch_next      = 1'b0;
      elapsed_ticks_next       = 16'd0;
    end
    if (start_ok) begin
      waiting_reply_next       = 1'b1;
      expected_data_bytes_next = {register_count, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_reply       <= 1'b0;
      bytes_received      <= 9'd0;
      expected_data_bytes <= 8'd0;
      running_crc         <= mrrm_pkg::CRC_INIT;
      crc_low_seen        <= 8'd0;
      header_mismatch     <= 1'b0;
      count_mismatch      <= 1'b0;
      elapsed_ticks       <= 16'd0;
    end else begin
      waiting_reply       <= waiting_reply_next;
      bytes_received      <= bytes_received_next;
      expected_data_bytes <= expected_data_bytes_next;
      running_crc         <= running_crc_next;
      crc_low_seen        <= crc_low_seen_next;
      header_mismatch     <= header_mismatch_next;
      count_mismatch      <= count_mismatch_next;
      elapsed_ticks       <= elapsed_ticks_next;
    end
  end

endmodule

// ----- tb/tb_modbus_rtu_register_read_master_core.sv -----
// Self-checking testbench for the Modbus RTU read-holding-registers master core.
module tb_modbus_rtu_register_read_master_core;

  // Kind code the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles to let the block finish silent work before touching registers
  localparam int SETTLE_CYCLES = 24;

  typedef enum int {
    FLAW_NONE,
    FLAW_ADDRESS,
    FLAW_FUNCTION,
    FLAW_COUNT,
    FLAW_CRC,
    FLAW_CRC_ADDRESS,
    FLAW_FUNC_COUNT,
    FLAW_SHORT
  } reply_flaw_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last_flag;
    logic [2:0] status;
  } reply_item_t;

  // Mirror of the master: predicts result items and checks them in order.
  class modbus_master_scoreboard;
    reply_item_t pending_results[$];
    logic [7:0]  slave_addr;
    logic [15:0] timeout_limit;
    bit          busy;
    int          rx_count;
    logic [7:0]  data_len;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    bit          header_bad;
    bit          count_bad;
    logic [15:0] tick_count;
    int          mismatches;

    function new();
      slave_addr    = mrrm_pkg::SLAVE_ADDRESS_RESET;
      timeout_limit = mrrm_pkg::TIMEOUT_TICKS_RESET;
      mismatches    = 0;
      restart();
    endfunction

    function void restart();
      busy       = 0;
      rx_count   = 0;
      data_len   = 8'd0;
      crc_acc    = mrrm_pkg::CRC_INIT;
      crc_lo     = 8'd0;
      header_bad = 0;
      count_bad  = 0;
      tick_count = 16'd0;
    endfunction

    function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      c[7:0] = c[7:0] ^ b;
      repeat (8) c = c[0] ? ((c >> 1) ^ mrrm_pkg::CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == mrrm_pkg::REG_SLAVE_ADDRESS) slave_addr = value[7:0];
      else timeout_limit = value[15:0];
    endfunction

    function void push(logic [1:0] kind, logic [7:0] value, logic last_flag,
                       logic [2:0] status);
      reply_item_t r;
      r.kind = kind;
      r.value = value;
      r.last_flag = last_flag;
      r.status = status;
      pending_results.push_back(r);
    endfunction

    // Returns 1 when the item had any effect on the block
    function bit accept_item(logic [1:0] kind, logic [15:0] addr, logic [6:0] cnt,
                             logic [7:0] rx);
      logic [7:0]  req [6];
      logic [15:0] c;
      logic [15:0] got;
      logic [2:0]  st;
      int          total;
      case (kind)
        mrrm_pkg::KIND_START: begin
          restart();
          if (cnt < 1 || cnt > mrrm_pkg::MaxRegisters) begin
            push(mrrm_pkg::RK_DONE, 8'd0, 1'b1, mrrm_pkg::ST_BAD_COUNT);
            return 1;
          end
          req[0] = slave_addr;
          req[1] = mrrm_pkg::FUNC_READ_HOLDING;
          req[2] = addr[15:8];
          req[3] = addr[7:0];
          req[4] = mrrm_pkg::COUNT_HIGH_BYTE;
          req[5] = {1'b0, cnt};
          c = mrrm_pkg::CRC_INIT;
          for (int i = 0; i < 6; i++) begin
            c = crc_byte(c, req[i]);
            push(mrrm_pkg::RK_REQUEST, req[i], 1'b0, mrrm_pkg::ST_OK);
          end
          push(mrrm_pkg::RK_REQUEST, c[7:0], 1'b0, mrrm_pkg::ST_OK);
          push(mrrm_pkg::RK_REQUEST, c[15:8], 1'b1, mrrm_pkg::ST_OK);
          busy = 1;
          data_len = {cnt, 1'b0};
          return 1;
        end
        mrrm_pkg::KIND_BYTE: begin
          if (!busy) return 0;
          total = 5 + data_len;
          rx_count++;
          if (rx_count - 1 < total - 2) begin
            crc_acc = crc_byte(crc_acc, rx);
            if (rx_count == 1 && rx != slave_addr) header_bad = 1;
            if (rx_count == 2 && rx != mrrm_pkg::FUNC_READ_HOLDING) header_bad = 1;
            if (rx_count == 3 && rx != data_len) count_bad = 1;
            if (rx_count >= 4) push(mrrm_pkg::RK_DATA, rx, 1'b0, mrrm_pkg::ST_OK);
          end else if (rx_count - 1 == total - 2) begin
            crc_lo = rx;
          end else begin
            got = {rx, crc_lo};
            if (got != crc_acc) st = mrrm_pkg::ST_CRC;
            else if (header_bad) st = mrrm_pkg::ST_ADDR_FUNC;
            else if (count_bad) st = mrrm_pkg::ST_BYTE_COUNT;
            else st = mrrm_pkg::ST_OK;
            restart();
            push(mrrm_pkg::RK_DONE, 8'd0, 1'b1, st);
          end
          return 1;
        end
        mrrm_pkg::KIND_TICK: begin
          if (!busy) return 0;
          if (tick_count != 16'hFFFF) tick_count++;
          if (tick_count >= timeout_limit) begin
            restart();
            push(mrrm_pkg::RK_DONE, 8'd0, 1'b1, mrrm_pkg::ST_TIMEOUT);
          end
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] value, logic last_flag,
                               logic [2:0] status);
      reply_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %02h last %0b status %0d",
                   kind, value, last_flag, status);
        return;
      end
      want = pending_results.pop_front();
      if (want.kind !== kind || want.value !== value || want.last_flag !== last_flag ||
          want.status !== status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected kind %0d byte %02h last %0b status %0d, %s",
                   want.kind, want.value, want.last_flag, want.status,
                   $sformatf("got kind %0d byte %02h last %0b status %0d",
                             kind, value, last_flag, status));
      end
    endfunction

    function void check_drained();
      if (pending_results.size() != 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0d expected results never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [31:0] s_tdata = 32'd0;   // [15:0] register_address, [22:16] register_count,
                                  // [30:23] received_byte, [31] zero
  logic [1:0]  s_tuser = 2'd0;    // [1:0] kind
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [15:0] m_tdata;           // [7:0] byte_value, [10:8] status, [15:11] zero
  wire  [1:0]  m_tuser;           // [1:0] result_kind
  wire         m_tlast;           // last_of_run
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  wire  [31:0] prdata;
  wire         pready;

  modbus_master_scoreboard sb = new();

  // Idle odds in percent, changed per phase
  int send_idle = 0;
  int recv_idle = 0;
  int items_sent = 0;

  modbus_rtu_register_read_master_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Check each accepted result, then pick the next ready value
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[7:0], m_tlast, m_tdata[10:8]);
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Drive one input item, idling at random before it; hold until accepted
  task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [6:0] cnt, input logic [7:0] rx);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, rx, cnt, addr};
    do @(posedge clk); while (!s_tready);
    if (sb.accept_item(kind, addr, cnt, rx)) items_sent++;
  endtask

  task automatic send_tick();
    send_item(mrrm_pkg::KIND_TICK, 16'($urandom_range(0, 65535)),
              7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
  endtask

  // Setup cycle, then access cycle; the register takes the value on the access edge
  task automatic write_register(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // Drop valid and wait out every predicted result plus the silent pipeline work
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Close any open transaction with a bad-count start so the block is truly idle
  task automatic settle();
    if (sb.busy) send_item(mrrm_pkg::KIND_START, 16'($urandom_range(0, 65535)), 7'd0, 8'd0);
    drain_results();
  endtask

  // Start a read and feed back a reply, damaged as asked, with ticks mixed in
  task automatic run_transaction(input logic [15:0] addr, input int cnt,
                                 input reply_flaw_t flaw, input int tick_pct);
    logic [7:0]  frame[$];
    logic [15:0] c;
    int          n;
    send_item(mrrm_pkg::KIND_START, addr, 7'(cnt), 8'($urandom_range(0, 255)));
    frame.push_back(sb.slave_addr);
    frame.push_back(mrrm_pkg::FUNC_READ_HOLDING);
    frame.push_back(8'(2 * cnt));
    if (flaw == FLAW_ADDRESS || flaw == FLAW_CRC_ADDRESS)
      frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_FUNCTION || flaw == FLAW_FUNC_COUNT)
      frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_COUNT || flaw == FLAW_FUNC_COUNT)
      frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
    repeat (2 * cnt) frame.push_back(8'($urandom_range(0, 255)));
    c = mrrm_pkg::CRC_INIT;
    foreach (frame[i]) c = sb.crc_byte(c, frame[i]);
    if (flaw == FLAW_CRC || flaw == FLAW_CRC_ADDRESS) begin
      if ($urandom_range(0, 1)) c[7:0] = c[7:0] ^ 8'($urandom_range(1, 255));
      else c[15:8] = c[15:8] ^ 8'($urandom_range(1, 255));
    end
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
    n = (flaw == FLAW_SHORT) ? $urandom_range(0, frame.size() - 1) : frame.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      send_item(mrrm_pkg::KIND_BYTE, 16'($urandom_range(0, 65535)),
                7'($urandom_range(0, 127)), frame[i]);
    end
    // Run a cut-off reply into its timeout when that is cheap
    if (flaw == FLAW_SHORT && sb.timeout_limit <= 300)
      while (sb.busy) send_tick();
  endtask

  task automatic run_random_transaction();
    int          r;
    int          cnt;
    reply_flaw_t flaw;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: stray bytes, ticks and unused kinds
      send_item(2'($urandom_range(1, 3)), 16'($urandom_range(0, 65535)),
                7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
    end else if (r < 14) begin
      cnt = $urandom_range(0, 2);
      send_item(mrrm_pkg::KIND_START, 16'($urandom_range(0, 65535)),
                (cnt == 0) ? 7'd0 : 7'(125 + cnt), 8'($urandom_range(0, 255)));
    end else begin
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE :
             reply_flaw_t'($urandom_range(FLAW_ADDRESS, FLAW_SHORT));
      run_transaction(16'($urandom_range(0, 65535)), cnt, flaw, 8);
    end
  endtask

  initial begin
    bit paused;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle noise, bad counts, a clean read, a restart, a bad reply
    send_item(mrrm_pkg::KIND_BYTE, 16'h0000, 7'd0, 8'hFF);
    send_item(mrrm_pkg::KIND_TICK, 16'hFFFF, 7'h7F, 8'h00);
    send_item(KIND_UNUSED, 16'h0000, 7'd1, 8'h00);
    send_item(mrrm_pkg::KIND_START, 16'h0000, 7'd0, 8'h00);
    send_item(mrrm_pkg::KIND_START, 16'hFFFF, 7'd126, 8'hFF);
    send_item(mrrm_pkg::KIND_START, 16'h5A5A, 7'd127, 8'h00);
    run_transaction(16'hFFFF, 1, FLAW_NONE, 0);
    send_item(mrrm_pkg::KIND_START, 16'h0000, 7'd125, 8'h00);
    // restart while the long read is pending, then a reply with bad CRC and address
    run_transaction(16'h8001, 2, FLAW_CRC_ADDRESS, 0);
    settle();
    write_register(mrrm_pkg::REG_SLAVE_ADDRESS, 32'hFF);
    write_register(mrrm_pkg::REG_TIMEOUT_TICKS, 32'h0);
    // zero timeout: the first tick after the request ends it
    send_item(mrrm_pkg::KIND_START, 16'h1234, 7'd3, 8'h00);
    send_tick();

    // Random, sender idles rarely, receiver mostly stalls
    settle();
    send_idle = 11;
    recv_idle = 86;
    write_register(mrrm_pkg::REG_SLAVE_ADDRESS, 32'h00);
    write_register(mrrm_pkg::REG_TIMEOUT_TICKS, 32'($urandom_range(3, 10)));
    while (items_sent < 80) run_random_transaction();

    // Random, roles swapped; pause once until every result is out
    settle();
    send_idle = 86;
    recv_idle = 11;
    paused = 0;
    write_register(mrrm_pkg::REG_SLAVE_ADDRESS, 32'($urandom_range(1, 254)));
    write_register(mrrm_pkg::REG_TIMEOUT_TICKS, 32'd1);
    while (items_sent < 110) begin
      if (!paused && items_sent >= 95) begin
        drain_results();
        paused = 1;
      end
      run_random_transaction();
    end

    // Random at full rate, including one read of the largest count
    settle();
    send_idle = 0;
    recv_idle = 0;
    write_register(mrrm_pkg::REG_SLAVE_ADDRESS, 32'($urandom_range(0, 255)));
    write_register(mrrm_pkg::REG_TIMEOUT_TICKS, 32'hFFFF);
    run_transaction(16'($urandom_range(0, 65535)), mrrm_pkg::MaxRegisters, FLAW_NONE, 0);
    while (items_sent < 370) run_random_transaction();

    drain_results();
    sb.check_drained();
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mrrm_pkg.sv
design/mrrm_req_gen.sv
design/mrrm_reply.sv
design/modbus_rtu_register_read_master_core.sv
tb/tb_modbus_rtu_register_read_master_core.sv
